FILE: hw/rtl/ljpm_pkg.sv
// Lepton-jet pair mass: shared constants and elaboration-time table functions.
// No dependencies; used by the channel interfaces and the top level.
package ljpm_pkg;

    // Pair selection codes held in the mode register
    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_CLOSEST = 3'd0;
    localparam logic [MODE_W-1:0] MODE_COMPL   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_L1J1    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_L1J2    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_L2J1    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_L2J2    = 3'd5;

    // Fixed-point format of the angle factor
    localparam int          FRAC         = 40;
    localparam int          G_W          = 64;
    localparam int          SERIES_TERMS = 24;
    localparam logic [63:0] PI_Q62       = 64'hC90FDAA22168C234;

    // Q40 product, truncated to 64 bits
    function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[FRAC+63:FRAC];
    endfunction

    // Half of an angle difference in radians, Q40
    function automatic logic [63:0] half_angle_q(input logic [63:0] steps, input int ab);
        logic [63:0] k;
        logic [63:0] m;
        k = PI_Q62 >> (ab + 2);
        m = steps * k;
        return m >> 20;
    endfunction

    // sinh(u)^2 in Q40 for an eta difference given in steps
    function automatic logic [63:0] sinh_sq_q(input logic [63:0] steps, input int ab);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] t;
        logic [63:0] sum;
        u   = half_angle_q(steps, ab);
        u2  = mul_q(u, u);
        t   = u;
        sum = '0;
        for (int n = 0; n < SERIES_TERMS; n++) begin
            sum = sum + t;
            t   = mul_q(t, u2) / 64'((2 * n + 2) * (2 * n + 3));
        end
        return mul_q(sum, sum);
    endfunction

    // sin(v)^2 in Q40 for a phi difference given in steps
    function automatic logic [63:0] sin_sq_q(input logic [63:0] steps, input int ab);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] t;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] sn;
        u   = half_angle_q(steps, ab);
        u2  = mul_q(u, u);
        t   = u;
        pos = '0;
        neg = '0;
        for (int n = 0; n < SERIES_TERMS; n++) begin
            if ((n & 1) == 1)
                neg = neg + t;
            else
                pos = pos + t;
            t  = mul_q(t, u2) / 64'((2 * n + 2) * (2 * n + 3));
        end
        sn = (pos > neg) ? pos - neg : '0;
        return mul_q(sn, sn);
    endfunction

endpackage

FILE: hw/rtl/ljpm_if.sv
// Lepton-jet pair mass: valid/ready channel interfaces (candidates, result, mode).
// Depends on ljpm_pkg for the mode register width.
interface ljpm_in_if #(
    parameter int PT_BITS    = 16,
    parameter int ANGLE_BITS = 10
);
    logic                       valid;
    logic                       ready;
    logic [PT_BITS-1:0]         lep1_pt;
    logic signed [ANGLE_BITS:0] lep1_eta;
    logic signed [ANGLE_BITS-1:0] lep1_phi;
    logic [PT_BITS-1:0]         lep2_pt;
    logic signed [ANGLE_BITS:0] lep2_eta;
    logic signed [ANGLE_BITS-1:0] lep2_phi;
    logic [PT_BITS-1:0]         jet1_pt;
    logic signed [ANGLE_BITS:0] jet1_eta;
    logic signed [ANGLE_BITS-1:0] jet1_phi;
    logic [PT_BITS-1:0]         jet2_pt;
    logic signed [ANGLE_BITS:0] jet2_eta;
    logic signed [ANGLE_BITS-1:0] jet2_phi;

    modport source (
        output valid, lep1_pt, lep1_eta, lep1_phi, lep2_pt, lep2_eta, lep2_phi,
               jet1_pt, jet1_eta, jet1_phi, jet2_pt, jet2_eta, jet2_phi,
        input  ready
    );
    modport sink (
        input  valid, lep1_pt, lep1_eta, lep1_phi, lep2_pt, lep2_eta, lep2_phi,
               jet1_pt, jet1_eta, jet1_phi, jet2_pt, jet2_eta, jet2_phi,
        output ready
    );
endinterface

interface ljpm_out_if #(
    parameter int PT_BITS = 16
);
    logic               valid;
    logic               ready;
    logic [PT_BITS-1:0] pair_mass;
    logic               mass_valid;

    modport source (output valid, pair_mass, mass_valid, input ready);
    modport sink (input valid, pair_mass, mass_valid, output ready);
endinterface

interface ljpm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ljpm_pkg::MODE_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: hw/rtl/lepton_jet_pair_mass_top.sv
// Throughput: one transaction per cycle; the whole pipeline holds while the result waits.
// Depth: seven arithmetic stages, a root load stage, one root bit per stage, output register.
// Reset: rst_n clears all valid bits and the pair mode (closest pair); no clearing pass.
// Lepton-jet pair mass top level: deltaR pairing, angle tables, mass and square root.
// Depends on ljpm_pkg and the channel interfaces in ljpm_if.sv.
module lepton_jet_pair_mass_top #(
    parameter int PT_BITS    = 16,
    parameter int ANGLE_BITS = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    ljpm_cfg_if.sink          cfg,
    ljpm_in_if.sink           pair_in,
    ljpm_out_if.source        pair_out
);

    localparam int PW       = PT_BITS;
    localparam int EW       = ANGLE_BITS + 1;
    localparam int AW       = ANGLE_BITS;
    localparam int SEPW     = 2 * EW + 1;
    localparam int SH_DEPTH = 2 ** EW;
    localparam int SN_DEPTH = 2 ** (AW - 1) + 1;
    localparam int GW       = ljpm_pkg::G_W;
    localparam int GH       = GW / 2;
    localparam int PPW      = PW + GH;
    localparam int FW       = 2 * PW + GW;
    localparam int QLO      = ljpm_pkg::FRAC;
    localparam int RW       = 2 * PW;

    // Mode register
    logic [ljpm_pkg::MODE_W-1:0] mode_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= ljpm_pkg::MODE_CLOSEST;
        else if (cfg.valid)
            mode_reg <= cfg.data;
    end

    // Global advance: hold everything while the result is not taken
    logic out_v_reg;
    logic pipe_en;

    assign pipe_en       = !out_v_reg || pair_out.ready;
    assign pair_in.ready = pipe_en;

    // Angle tables: squared sinh and sin of the half differences
    logic [GW-1:0] sh2_rom [SH_DEPTH];
    logic [GW-1:0] sn2_rom [SN_DEPTH];

    for (genvar i = 0; i < SH_DEPTH; i++) begin : g_sh_rom
        localparam logic [GW-1:0] ENTRY = ljpm_pkg::sinh_sq_q(64'(i), ANGLE_BITS);
        assign sh2_rom[i] = ENTRY;
    end

    for (genvar i = 0; i < SN_DEPTH; i++) begin : g_sn_rom
        localparam logic [GW-1:0] ENTRY = ljpm_pkg::sin_sq_q(64'(i), ANGLE_BITS);
        assign sn2_rom[i] = ENTRY;
    end

    // Stage 1: absolute eta and wrapped phi differences of the four pairs
    logic [1:0][PW-1:0]  lep_pt;
    logic [1:0][EW-1:0]  lep_eta;
    logic [1:0][AW-1:0]  lep_phi;
    logic [1:0][PW-1:0]  jet_pt;
    logic [1:0][EW-1:0]  jet_eta;
    logic [1:0][AW-1:0]  jet_phi;
    logic [3:0][EW-1:0]  deta;
    logic [3:0][AW-1:0]  dphi;

    always_comb
    begin
        lep_pt[0]  = pair_in.lep1_pt;
        lep_eta[0] = pair_in.lep1_eta;
        lep_phi[0] = pair_in.lep1_phi;
        lep_pt[1]  = pair_in.lep2_pt;
        lep_eta[1] = pair_in.lep2_eta;
        lep_phi[1] = pair_in.lep2_phi;
        jet_pt[0]  = pair_in.jet1_pt;
        jet_eta[0] = pair_in.jet1_eta;
        jet_phi[0] = pair_in.jet1_phi;
        jet_pt[1]  = pair_in.jet2_pt;
        jet_eta[1] = pair_in.jet2_eta;
        jet_phi[1] = pair_in.jet2_phi;
        // an absent first jet sits at the origin
        if (pair_in.jet1_pt == '0)
        begin
            jet_eta[0] = '0;
            jet_phi[0] = '0;
        end
    end

    always_comb
    begin
        logic signed [EW:0]   de;
        logic signed [AW-1:0] dp;
        for (int p = 0; p < 4; p++) begin
            de = $signed({lep_eta[p >> 1][EW-1], lep_eta[p >> 1]})
               - $signed({jet_eta[p & 1][EW-1], jet_eta[p & 1]});
            dp = $signed(lep_phi[p >> 1] - jet_phi[p & 1]);
            deta[p] = de[EW] ? EW'(-de) : de[EW-1:0];
            dphi[p] = dp[AW-1] ? AW'(-dp) : dp;
        end
    end

    logic                s1_v_reg;
    logic [3:0][EW-1:0]  s1_deta_reg;
    logic [3:0][AW-1:0]  s1_dphi_reg;
    logic [1:0][PW-1:0]  s1_lpt_reg;
    logic [1:0][PW-1:0]  s1_jpt_reg;
    logic                s1_noj2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (pipe_en)
            s1_v_reg <= pair_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_deta_reg <= deta;
            s1_dphi_reg <= dphi;
            s1_lpt_reg  <= lep_pt;
            s1_jpt_reg  <= jet_pt;
            s1_noj2_reg <= (pair_in.jet2_pt == '0);
        end
    end

    // Stage 2: squared separations
    logic                s2_v_reg;
    logic [3:0][SEPW-1:0] s2_sep_reg;
    logic [3:0][EW-1:0]  s2_deta_reg;
    logic [3:0][AW-1:0]  s2_dphi_reg;
    logic [1:0][PW-1:0]  s2_lpt_reg;
    logic [1:0][PW-1:0]  s2_jpt_reg;
    logic                s2_noj2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (pipe_en)
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int p = 0; p < 4; p++) begin
                s2_sep_reg[p] <= SEPW'(s1_deta_reg[p] * s1_deta_reg[p])
                               + SEPW'(s1_dphi_reg[p] * s1_dphi_reg[p]);
            end
            s2_deta_reg <= s1_deta_reg;
            s2_dphi_reg <= s1_dphi_reg;
            s2_lpt_reg  <= s1_lpt_reg;
            s2_jpt_reg  <= s1_jpt_reg;
            s2_noj2_reg <= s1_noj2_reg;
        end
    end

    // Stage 3: pick the pair; ties go to the later of l1j1/l1j2, then strict
    logic [1:0]      near_idx;
    logic [1:0]      sel_idx;
    logic [SEPW-1:0] best;

    always_comb
    begin
        if (s2_sep_reg[0] < s2_sep_reg[1])
        begin
            near_idx = 2'd0;
            best     = s2_sep_reg[0];
        end
        else
        begin
            near_idx = 2'd1;
            best     = s2_sep_reg[1];
        end
        if (s2_sep_reg[2] < best)
        begin
            near_idx = 2'd2;
            best     = s2_sep_reg[2];
        end
        if (s2_sep_reg[3] < best)
            near_idx = 2'd3;

        unique case (mode_reg)
            ljpm_pkg::MODE_COMPL: sel_idx = ~near_idx;
            ljpm_pkg::MODE_L1J1:  sel_idx = 2'd0;
            ljpm_pkg::MODE_L1J2:  sel_idx = 2'd1;
            ljpm_pkg::MODE_L2J1:  sel_idx = 2'd2;
            ljpm_pkg::MODE_L2J2:  sel_idx = 2'd3;
            default:              sel_idx = near_idx;
        endcase
    end

    logic          s3_v_reg;
    logic [EW-1:0] s3_deta_reg;
    logic [AW-1:0] s3_dphi_reg;
    logic [PW-1:0] s3_pta_reg;
    logic [PW-1:0] s3_ptb_reg;
    logic          s3_noj2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else if (pipe_en)
            s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s3_deta_reg <= s2_deta_reg[sel_idx];
            s3_dphi_reg <= s2_dphi_reg[sel_idx];
            s3_pta_reg  <= s2_lpt_reg[sel_idx[1]];
            s3_ptb_reg  <= s2_jpt_reg[sel_idx[0]];
            s3_noj2_reg <= s2_noj2_reg;
        end
    end

    // Stage 4: table reads and pt product
    logic            s4_v_reg;
    logic [GW-1:0]   s4_sh2_reg;
    logic [GW-1:0]   s4_sn2_reg;
    logic [2*PW-1:0] s4_ptp_reg;
    logic            s4_noj2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_v_reg <= 1'b0;
        else if (pipe_en)
            s4_v_reg <= s3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s4_sh2_reg  <= sh2_rom[s3_deta_reg];
            s4_sn2_reg  <= sn2_rom[s3_dphi_reg];
            s4_ptp_reg  <= (2*PW)'(s3_pta_reg * s3_ptb_reg);
            s4_noj2_reg <= s3_noj2_reg;
        end
    end

    // Stage 5: angle factor G = 2*(cosh(deta) - cos(dphi)) in Q40
    logic            s5_v_reg;
    logic [GW-1:0]   s5_g_reg;
    logic [2*PW-1:0] s5_ptp_reg;
    logic            s5_noj2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_v_reg <= 1'b0;
        else if (pipe_en)
            s5_v_reg <= s4_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s5_g_reg    <= (s4_sh2_reg + s4_sn2_reg) << 2;
            s5_ptp_reg  <= s4_ptp_reg;
            s5_noj2_reg <= s4_noj2_reg;
        end
    end

    // Stage 6: partial products of pt product and G
    logic           s6_v_reg;
    logic [PPW-1:0] s6_pp00_reg;
    logic [PPW-1:0] s6_pp01_reg;
    logic [PPW-1:0] s6_pp10_reg;
    logic [PPW-1:0] s6_pp11_reg;
    logic           s6_noj2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_v_reg <= 1'b0;
        else if (pipe_en)
            s6_v_reg <= s5_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s6_pp00_reg <= PPW'(s5_ptp_reg[PW-1:0] * s5_g_reg[GH-1:0]);
            s6_pp01_reg <= PPW'(s5_ptp_reg[PW-1:0] * s5_g_reg[GW-1:GH]);
            s6_pp10_reg <= PPW'(s5_ptp_reg[2*PW-1:PW] * s5_g_reg[GH-1:0]);
            s6_pp11_reg <= PPW'(s5_ptp_reg[2*PW-1:PW] * s5_g_reg[GW-1:GH]);
            s6_noj2_reg <= s5_noj2_reg;
        end
    end

    // Stage 7: squared mass, saturate when the root cannot fit
    logic [FW-1:0] full_prod;

    assign full_prod = FW'(s6_pp00_reg)
                     + (FW'(s6_pp01_reg) << GH)
                     + (FW'(s6_pp10_reg) << PW)
                     + (FW'(s6_pp11_reg) << (PW + GH));

    logic          s7_v_reg;
    logic [RW-1:0] s7_q_reg;
    logic          s7_sat_reg;
    logic          s7_noj2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_v_reg <= 1'b0;
        else if (pipe_en)
            s7_v_reg <= s6_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s7_q_reg    <= full_prod[QLO+RW-1:QLO];
            s7_sat_reg  <= |full_prod[FW-1:QLO+RW];
            s7_noj2_reg <= s6_noj2_reg;
        end
    end

    // Square root: one result bit per stage
    logic [PW:0]   iq_v_reg;
    logic [RW-1:0] iq_rem_reg [PW+1];
    logic [RW-1:0] iq_r_reg   [PW+1];
    logic [PW:0]   iq_sat_reg;
    logic [PW:0]   iq_noj2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iq_v_reg[0] <= 1'b0;
        else if (pipe_en)
            iq_v_reg[0] <= s7_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            iq_rem_reg[0]  <= s7_q_reg;
            iq_r_reg[0]    <= '0;
            iq_sat_reg[0]  <= s7_sat_reg;
            iq_noj2_reg[0] <= s7_noj2_reg;
        end
    end

    for (genvar k = 0; k < PW; k++) begin : g_isqrt
        localparam logic [RW:0] BIT = (RW+1)'(1) << (RW - 2 - 2 * k);
        logic [RW:0] trial;

        assign trial = {1'b0, iq_r_reg[k]} + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                iq_v_reg[k+1] <= 1'b0;
            else if (pipe_en)
                iq_v_reg[k+1] <= iq_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                if ({1'b0, iq_rem_reg[k]} >= trial)
                begin
                    iq_rem_reg[k+1] <= RW'({1'b0, iq_rem_reg[k]} - trial);
                    iq_r_reg[k+1]   <= RW'(({1'b0, iq_r_reg[k]} >> 1) + BIT);
                end
                else
                begin
                    iq_rem_reg[k+1] <= iq_rem_reg[k];
                    iq_r_reg[k+1]   <= iq_r_reg[k] >> 1;
                end
                iq_sat_reg[k+1]  <= iq_sat_reg[k];
                iq_noj2_reg[k+1] <= iq_noj2_reg[k];
            end
        end
    end

    // Output stage: round to nearest, saturate, blank when the second jet is absent
    logic          round_up;
    logic [PW:0]   rounded;
    logic [PW-1:0] mass_next;

    assign round_up = iq_rem_reg[PW] > iq_r_reg[PW];
    assign rounded  = {1'b0, iq_r_reg[PW][PW-1:0]} + (PW+1)'(round_up);

    always_comb
    begin
        priority if (iq_noj2_reg[PW])
            mass_next = '0;
        else if (iq_sat_reg[PW] || rounded[PW])
            mass_next = '1;
        else
            mass_next = rounded[PW-1:0];
    end

    logic [PW-1:0] out_mass_reg;
    logic          out_mv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (pipe_en)
            out_v_reg <= iq_v_reg[PW];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            out_mass_reg <= mass_next;
            out_mv_reg   <= !iq_noj2_reg[PW];
        end
    end

    assign pair_out.valid      = out_v_reg;
    assign pair_out.pair_mass  = out_mass_reg;
    assign pair_out.mass_valid = out_mv_reg;

`ifndef ASSERT_OFF
    // A held pipeline keeps the valid bits of stage 1, stage 4 and the root stages
    a_hold_valids: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(iq_v_reg) && $stable(s1_v_reg) && $stable(s4_v_reg))
        else $error("pipeline valid bits moved during a stall");

    // An invalid result carries a zero mass
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pair_out.valid && !pair_out.mass_valid |-> pair_out.pair_mass == '0)
        else $error("invalid result with nonzero mass");

    // A waiting result blocks new input transactions
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        pair_out.valid && !pair_out.ready |-> !pair_in.ready)
        else $error("input accepted while result stalled");
`endif

endmodule

FILE: tb/lepton_jet_pair_mass_top_tb.sv
// Testbench for lepton_jet_pair_mass_top: random and directed candidate sets,
// scored against an in-bench predictor. Depends on ljpm_pkg and ljpm_if.sv.
`timescale 1ns / 1ps

module lepton_jet_pair_mass_top_tb;

    localparam int PT_BITS    = 16;
    localparam int ANGLE_BITS = 10;
    localparam int LATENCY    = 9 + PT_BITS;
    localparam int WATCHDOG   = 20000;
    localparam int N_RANDOM   = 1750;
    localparam logic [63:0] PI_STEP = 64'hC90FDAA22168C234 >> (ANGLE_BITS + 2);

    typedef struct packed {
        logic [PT_BITS-1:0]         pt;
        logic signed [ANGLE_BITS:0] eta;
        logic signed [ANGLE_BITS-1:0] phi;
    } cand_t;

    typedef struct packed {
        cand_t l1;
        cand_t l2;
        cand_t j1;
        cand_t j2;
    } event_t;

    typedef struct packed {
        logic [PT_BITS-1:0] mass;
        logic               ok;
    } mass_t;

    logic clk;
    logic rst_n;

    ljpm_cfg_if                                           cfg ();
    ljpm_in_if #(.PT_BITS(PT_BITS), .ANGLE_BITS(ANGLE_BITS)) pair_in ();
    ljpm_out_if #(.PT_BITS(PT_BITS))                       pair_out ();

    lepton_jet_pair_mass_top #(.PT_BITS(PT_BITS), .ANGLE_BITS(ANGLE_BITS)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg.sink),
        .pair_in  (pair_in.sink),
        .pair_out (pair_out.source)
    );

    event_t                      pending_events[$];
    mass_t                       expected_masses[$];
    logic [ljpm_pkg::MODE_W-1:0] pair_mode;
    int                          error_count;
    int                          idle_cycles;
    int                          hold_off;
    int                          in_gap;
    int                          long_hold_req;
    int                          long_hold_seen;
    bit                          in_taken;

    // Q40 product, truncated
    function automatic logic [63:0] q40_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[103:40];
    endfunction

    // Series sum for sinh (alternate=0) or sin (alternate=1) of half the step angle
    function automatic logic [63:0] half_series(input logic [63:0] steps, input bit alternate);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] t;
        logic [63:0] pos;
        logic [63:0] neg;
        u   = (steps * PI_STEP) >> 20;
        u2  = q40_mul(u, u);
        t   = u;
        pos = 0;
        neg = 0;
        for (int n = 0; n < 24; n++)
        begin
            if (alternate && n % 2 == 1)
                neg = neg + t;
            else
                pos = pos + t;
            t = q40_mul(t, u2) / 64'((2 * n + 2) * (2 * n + 3));
        end
        return (pos > neg) ? pos - neg : 64'd0;
    endfunction

    function automatic logic [63:0] eta_gap(input cand_t a, input cand_t b);
        int d;
        d = int'(a.eta) - int'(b.eta);
        return 64'(d < 0 ? -d : d);
    endfunction

    function automatic logic [63:0] phi_gap(input cand_t a, input cand_t b);
        logic signed [ANGLE_BITS-1:0] d;
        d = a.phi - b.phi;
        return 64'(d < 0 ? -int'(d) : int'(d));
    endfunction

    function automatic logic [63:0] delta_r_sq(input cand_t a, input cand_t b);
        logic [63:0] de;
        logic [63:0] dp;
        de = eta_gap(a, b);
        dp = phi_gap(a, b);
        return de * de + dp * dp;
    endfunction

    // Invariant mass of a massless pair, rounded square root, saturating
    function automatic logic [PT_BITS-1:0] invariant_mass(input cand_t a, input cand_t b);
        logic [63:0]  sh;
        logic [63:0]  sn;
        logic [63:0]  g;
        logic [63:0]  ptp;
        logic [127:0] prod;
        logic [63:0]  q;
        logic [63:0]  r;
        logic [63:0]  bitv;
        sh   = half_series(eta_gap(a, b), 1'b0);
        sn   = half_series(phi_gap(a, b), 1'b1);
        g    = 4 * (q40_mul(sh, sh) + q40_mul(sn, sn));
        ptp  = 64'(a.pt) * 64'(b.pt);
        prod = {64'd0, ptp} * {64'd0, g};
        if (prod[127:104] != 0)
            return '1;
        q    = prod[103:40];
        r    = 0;
        bitv = 64'd1 << 62;
        while (bitv > q)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (q >= r + bitv)
            begin
                q = q - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        if (q > r)
            r = r + 1;
        return (r > 64'((1 << PT_BITS) - 1)) ? '1 : r[PT_BITS-1:0];
    endfunction

    function automatic mass_t predict_pair_mass(input event_t e,
                                                input logic [ljpm_pkg::MODE_W-1:0] mode);
        mass_t       res;
        cand_t       j1;
        logic [63:0] d[4];
        logic [63:0] best;
        int          idx;
        res = '0;
        if (e.j2.pt == 0)
            return res;
        j1 = e.j1;
        if (j1.pt == 0)
        begin
            j1.eta = 0;
            j1.phi = 0;
        end
        d[0] = delta_r_sq(e.l1, j1);
        d[1] = delta_r_sq(e.l1, e.j2);
        d[2] = delta_r_sq(e.l2, j1);
        d[3] = delta_r_sq(e.l2, e.j2);
        if (d[0] < d[1])
        begin
            idx  = 0;
            best = d[0];
        end
        else
        begin
            idx  = 1;
            best = d[1];
        end
        if (d[2] < best)
        begin
            idx  = 2;
            best = d[2];
        end
        if (d[3] < best)
            idx = 3;
        case (mode)
            ljpm_pkg::MODE_COMPL: idx = 3 - idx;
            ljpm_pkg::MODE_L1J1:  idx = 0;
            ljpm_pkg::MODE_L1J2:  idx = 1;
            ljpm_pkg::MODE_L2J1:  idx = 2;
            ljpm_pkg::MODE_L2J2:  idx = 3;
            default:              ;
        endcase
        res.ok   = 1'b1;
        res.mass = invariant_mass(idx[1] ? e.l2 : e.l1, idx[0] ? e.j2 : j1);
        return res;
    endfunction

    function automatic cand_t random_cand();
        cand_t c;
        int    sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            c.pt = '1;
        else if (sel < 3)
            c.pt = PT_BITS'($urandom());
        else
            c.pt = PT_BITS'($urandom_range(1, 800));
        if ($urandom_range(0, 19) == 0)
            c.pt = 0;
        if ($urandom_range(0, 3) == 0)
            c.eta = (ANGLE_BITS + 1)'($urandom());
        else
            c.eta = (ANGLE_BITS + 1)'(int'($urandom_range(0, 1600)) - 800);
        c.phi = ANGLE_BITS'($urandom());
        return c;
    endfunction

    function automatic event_t random_event();
        event_t e;
        e.l1 = random_cand();
        e.l2 = random_cand();
        e.j1 = random_cand();
        e.j2 = random_cand();
        // copy angles now and then to hit equal separations
        if ($urandom_range(0, 7) == 0)
            e.j2 = '{pt: e.j2.pt, eta: e.j1.eta, phi: e.j1.phi};
        return e;
    endfunction

    function automatic cand_t mk(input int pt, input int eta, input int phi);
        cand_t c;
        c.pt  = PT_BITS'(pt);
        c.eta = (ANGLE_BITS + 1)'(eta);
        c.phi = ANGLE_BITS'(phi);
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic wait_idle();
        while (pending_events.size() != 0 || expected_masses.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_mode(input logic [ljpm_pkg::MODE_W-1:0] mode);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= mode;
        do
            @(posedge clk);
        while (!cfg.ready);
        pair_mode = mode;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            pending_events.push_back(random_event());
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drive candidate sets; change at the falling edge, random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pair_in.valid <= 1'b0;
            in_gap        <= 0;
        end
        else if (!pair_in.valid || in_taken)
        begin
            if (in_gap > 0)
            begin
                in_gap        <= in_gap - 1;
                pair_in.valid <= 1'b0;
            end
            else if (pending_events.size() != 0 && $urandom_range(0, 99) < 2)
            begin
                in_gap        <= $urandom_range(10, 40);
                pair_in.valid <= 1'b0;
            end
            else if (pending_events.size() != 0 && $urandom_range(0, 3) != 0)
            begin
                {pair_in.lep1_pt, pair_in.lep1_eta, pair_in.lep1_phi,
                 pair_in.lep2_pt, pair_in.lep2_eta, pair_in.lep2_phi,
                 pair_in.jet1_pt, pair_in.jet1_eta, pair_in.jet1_phi,
                 pair_in.jet2_pt, pair_in.jet2_eta, pair_in.jet2_phi} <= pending_events[0];
                pair_in.valid <= 1'b1;
            end
            else
                pair_in.valid <= 1'b0;
        end
    end

    // Predict on every accepted input transaction and retire it from the queue
    always @(posedge clk)
    begin
        if (rst_n && pair_in.valid && pair_in.ready)
        begin
            expected_masses.push_back(predict_pair_mass(pending_events[0], pair_mode));
            void'(pending_events.pop_front());
        end
        in_taken <= rst_n && pair_in.valid && pair_in.ready;
    end

    // Receiver stall: random short/long gaps plus an explicit long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pair_out.ready <= 1'b0;
            hold_off       <= 0;
            long_hold_seen <= 0;
        end
        else if (long_hold_req != long_hold_seen)
        begin
            long_hold_seen <= long_hold_req;
            hold_off       <= 200;
            pair_out.ready <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off       <= hold_off - 1;
            pair_out.ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 2)
        begin
            hold_off       <= $urandom_range(10, 60);
            pair_out.ready <= 1'b0;
        end
        else
            pair_out.ready <= ($urandom_range(0, 3) != 0);
    end

    // Score results and run the watchdog
    always @(posedge clk)
    begin
        mass_t want;
        if (rst_n)
        begin
            if (pair_out.valid && pair_out.ready)
            begin
                if (expected_masses.size() == 0)
                    report_mismatch("unexpected result", pair_out.pair_mass, 0);
                else
                begin
                    want = expected_masses.pop_front();
                    if (pair_out.mass_valid !== want.ok)
                        report_mismatch("mass_valid", pair_out.mass_valid, want.ok);
                    if (pair_out.pair_mass !== want.mass)
                        report_mismatch("pair_mass", pair_out.pair_mass, want.mass);
                end
            end
            if ((pair_out.valid && pair_out.ready) || (pair_in.valid && pair_in.ready)
                || (cfg.valid && cfg.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG)
            begin
                $display("Verification failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus sequence
    initial
    begin
        error_count      = 0;
        idle_cycles      = 0;
        long_hold_req    = 0;
        pair_mode        = ljpm_pkg::MODE_CLOSEST;
        rst_n            = 1'b0;
        cfg.valid        = 1'b0;
        cfg.data         = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, missing jets, ties, wrap of phi
        pending_events.push_back('{mk(100, 0, 0), mk(100, 0, 0), mk(100, 0, 0), mk(0, 5, 5)});
        pending_events.push_back('{mk(400, 10, 10), mk(300, -10, -10),
                                   mk(0, 900, 300), mk(200, 40, 20)});
        pending_events.push_back('{mk(65535, 1023, 511), mk(65535, -1024, -512),
                                   mk(65535, -1024, -512), mk(65535, 1023, 511)});
        pending_events.push_back('{mk(200, 0, 0), mk(200, 50, 50),
                                   mk(200, 3, 0), mk(200, 0, 3)});
        pending_events.push_back('{mk(200, 0, 511), mk(200, 0, -512),
                                   mk(200, 0, -512), mk(200, 0, 511)});
        pending_events.push_back('{mk(1, 0, 0), mk(1, 0, 0), mk(1, 0, 0), mk(1, 0, 0)});
        pending_events.push_back('{mk(65535, 1023, 0), mk(0, 0, 0),
                                   mk(65535, -1024, 0), mk(65535, 0, -512)});
        pending_events.push_back('{mk(800, 20, 20), mk(800, 20, 20),
                                   mk(800, 20, 20), mk(800, 20, 20)});
        wait_idle();

        // Walk through every mode, extremes included
        for (int m = 0; m <= 5; m++)
        begin
            write_mode(ljpm_pkg::MODE_W'(m));
            queue_random(m == 0 ? 8 : 3);
            pending_events.push_back('{mk(300, 0, 0), mk(300, 200, -300),
                                       mk(300, 5, 5), mk(300, -400, 511)});
            wait_idle();
        end

        // Long receiver hold-off while the sender keeps offering
        write_mode(ljpm_pkg::MODE_CLOSEST);
        @(posedge clk);
        long_hold_req = long_hold_req + 1;
        queue_random(100);
        wait_idle();

        // Random bulk, a few mode changes along the way
        for (int phase = 0; phase < 6; phase++)
        begin
            write_mode(ljpm_pkg::MODE_W'($urandom_range(0, 5)));
            queue_random(N_RANDOM / 6);
            wait_idle();
        end
        write_mode(ljpm_pkg::MODE_L2J2);
        queue_random(20);
        wait_idle();

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
